// File: design/parameterized_match_counter_defines.svh
// Assertion macros used by the match counter controller.
`ifndef PARAMETERIZED_MATCH_COUNTER_DEFINES_SVH
`define PARAMETERIZED_MATCH_COUNTER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/pmc_pkg.sv
// Package with the types, constants and codes of the match counter.
`default_nettype none
package pmc_pkg;
    localparam int PatternMax = 1024;
    localparam int IdxW = 10;
    localparam int LenW = 11;
    localparam int AlphabetSize = 26;
    localparam int SymW = 5;
    localparam int PosW = 32;
    localparam int CntW = 32;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_PREP = 2'd1,
        MODE_TEXT = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_CLR, ST_D_RD, ST_D_WB, ST_F_INIT,
        ST_F_RI, ST_F_RD, ST_F_CMP, ST_F_FOL, ST_F_FWT, ST_F_WR,
        ST_T_RD, ST_T_CMP, ST_T_FOL, ST_T_FWT, ST_T_END, ST_T_LNK, ST_OUT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic clr_step;
        logic dist_rd;
        logic dist_wb;
        logic fail_init;
        logic rd_pair;
        logic fol_rd;
        logic fol_take;
        logic fail_wr;
        logic text_cmp_rd;
        logic hit_step;
        logic miss_step;
        logic link_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic dist_last;
        logic fail_last;
        logic j_zero;
        logic eq;
        logic j_is_end;
    } stat_t;

    function automatic logic [LenW-1:0] windowed(input logic [PosW-1:0] d,
                                                 input logic [LenW-1:0] w);
        logic [LenW-1:0] r;
        begin
            r = (d <= PosW'(w)) ? d[LenW-1:0] : '0;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// File: design/pmc_ram.sv
// Generic single-port-write, one-read RAM with a registered read.
`default_nettype none
module pmc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// File: design/pmc_ctrl.sv
// Sequencer for loading, table preparation and text processing.
`default_nettype none
`include "parameterized_match_counter_defines.svh"
module pmc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_fire,
    input  wire logic [1:0]     in_mode,
    input  wire logic           out_fire,
    input  wire pmc_pkg::stat_t stat,
    output pmc_pkg::cmd_t       cmd,
    output logic                in_ready,
    output logic                out_valid
);
    pmc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pmc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (in_mode)
                        pmc_pkg::MODE_LOAD: state_next = pmc_pkg::ST_LOAD;
                        pmc_pkg::MODE_PREP: state_next = pmc_pkg::ST_CLR;
                        pmc_pkg::MODE_TEXT: state_next = pmc_pkg::ST_T_RD;
                        default:            state_next = pmc_pkg::ST_OUT;
                    endcase
                end
            end
            pmc_pkg::ST_LOAD:   state_next = pmc_pkg::ST_OUT;
            pmc_pkg::ST_CLR:    if (stat.clr_done) state_next = pmc_pkg::ST_D_RD;
            pmc_pkg::ST_D_RD:   state_next = pmc_pkg::ST_D_WB;
            pmc_pkg::ST_D_WB:   state_next = stat.dist_last ? pmc_pkg::ST_F_INIT
                                                            : pmc_pkg::ST_D_RD;
            pmc_pkg::ST_F_INIT: state_next = stat.fail_last ? pmc_pkg::ST_OUT
                                                            : pmc_pkg::ST_F_RD;
            pmc_pkg::ST_F_RI:   state_next = pmc_pkg::ST_F_RD;
            pmc_pkg::ST_F_RD:   state_next = pmc_pkg::ST_F_CMP;
            pmc_pkg::ST_F_CMP:  state_next = (stat.j_zero || stat.eq) ? pmc_pkg::ST_F_WR
                                                                      : pmc_pkg::ST_F_FOL;
            pmc_pkg::ST_F_FOL:  state_next = pmc_pkg::ST_F_FWT;
            pmc_pkg::ST_F_FWT:  state_next = pmc_pkg::ST_F_RD;
            pmc_pkg::ST_F_WR:   state_next = stat.dist_last ? pmc_pkg::ST_OUT
                                                            : pmc_pkg::ST_F_RI;
            pmc_pkg::ST_T_RD:   state_next = pmc_pkg::ST_T_CMP;
            pmc_pkg::ST_T_CMP:  state_next = (stat.j_zero || stat.eq) ? pmc_pkg::ST_T_END
                                                                      : pmc_pkg::ST_T_FOL;
            pmc_pkg::ST_T_FOL:  state_next = pmc_pkg::ST_T_FWT;
            pmc_pkg::ST_T_FWT:  state_next = pmc_pkg::ST_T_RD;
            pmc_pkg::ST_T_END:  state_next = stat.j_is_end ? pmc_pkg::ST_T_LNK
                                                           : pmc_pkg::ST_OUT;
            pmc_pkg::ST_T_LNK:  state_next = pmc_pkg::ST_OUT;
            pmc_pkg::ST_OUT:    if (out_fire) state_next = pmc_pkg::ST_IDLE;
            default:            state_next = pmc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            pmc_pkg::ST_IDLE:   in_ready = 1'b1;
            pmc_pkg::ST_LOAD:   cmd.load_wr = 1'b1;
            pmc_pkg::ST_CLR:    cmd.clr_step = 1'b1;
            pmc_pkg::ST_D_RD:   cmd.dist_rd = 1'b1;
            pmc_pkg::ST_D_WB:   cmd.dist_wb = 1'b1;
            pmc_pkg::ST_F_INIT: cmd.fail_init = 1'b1;
            pmc_pkg::ST_F_RD:   cmd.rd_pair = 1'b1;
            pmc_pkg::ST_F_FOL:  cmd.fol_rd = 1'b1;
            pmc_pkg::ST_F_FWT:  cmd.fol_take = 1'b1;
            pmc_pkg::ST_F_WR:   cmd.fail_wr = 1'b1;
            pmc_pkg::ST_T_RD:   cmd.text_cmp_rd = 1'b1;
            pmc_pkg::ST_T_FOL:  cmd.fol_rd = 1'b1;
            pmc_pkg::ST_T_FWT:  cmd.fol_take = 1'b1;
            pmc_pkg::ST_T_END: begin
                cmd.hit_step = stat.j_is_end;
                cmd.miss_step = !stat.j_is_end;
            end
            pmc_pkg::ST_T_LNK:  cmd.link_take = 1'b1;
            pmc_pkg::ST_OUT:    out_valid = 1'b1;
            default: begin
            end
        endcase
        cmd.out_load = (state_next == pmc_pkg::ST_OUT) && (state_reg != pmc_pkg::ST_OUT);
    end

    `PMC_ASSERT_IMP(a_ready_idle, aclk, aresetn, in_ready, state_reg == pmc_pkg::ST_IDLE)
    `PMC_ASSERT_IMP(a_out_excl, aclk, aresetn, out_valid, !in_ready)
    `PMC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_fire, out_valid)
endmodule
`default_nettype wire

// File: design/pmc_dp.sv
// Datapath: pattern tables, letter history, matcher registers and result.
`default_nettype none
module pmc_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [pmc_pkg::LenW-1:0]  cfg_wdata,
    input  wire logic                      in_fire,
    input  wire logic [1:0]                in_mode,
    input  wire logic [pmc_pkg::SymW-1:0]  in_symbol,
    input  wire logic [pmc_pkg::IdxW-1:0]  in_index,
    input  wire pmc_pkg::cmd_t             cmd,
    output pmc_pkg::stat_t                 stat,
    output logic                           out_found,
    output logic [pmc_pkg::CntW-1:0]       out_count,
    output logic [pmc_pkg::LenW-1:0]       out_len
);
    localparam int LW = pmc_pkg::LenW;
    localparam int IW = pmc_pkg::IdxW;
    localparam int SW = pmc_pkg::SymW;
    localparam int PW = pmc_pkg::PosW;
    localparam int AW = $clog2(pmc_pkg::AlphabetSize);

    logic [LW-1:0] plen_reg, mlen_reg;
    logic [SW-1:0] sym_reg;
    logic [IW-1:0] idx_reg;
    logic [1:0]    mode_reg;
    logic [LW-1:0] i_reg, j_reg;
    logic [PW-1:0] pos_reg;
    logic [pmc_pkg::CntW-1:0] cnt_reg;
    logic [PW-1:0] rawd_reg;
    logic [pmc_pkg::AlphabetSize-1:0] seen_reg;
    logic [PW-1:0] last_reg [pmc_pkg::AlphabetSize];
    logic [LW-1:0] plast_reg [pmc_pkg::AlphabetSize];
    logic          out_found_reg;
    logic [pmc_pkg::CntW-1:0] out_count_reg;
    logic [LW-1:0] out_len_reg;
    logic [LW-1:0] clr_reg;
    logic [LW-1:0] dist_q_reg;

    logic [SW-1:0] csym;
    logic [SW-1:0] sym_rd;
    logic [LW-1:0] dist_rd_a, fail_rd;
    logic [IW-1:0] dist_ra, fail_ra, sym_ra;
    logic          dist_we, fail_we;
    logic [IW-1:0] dist_wa, fail_wa;
    logic [LW-1:0] dist_wd, fail_wd;
    logic [SW-1:0] dsym;
    logic [AW-1:0] dsa;
    logic [LW-1:0] lhs;
    logic [LW-1:0] jm1, mcl, nx, link_len;

    assign csym = (in_symbol < SW'(pmc_pkg::AlphabetSize)) ? in_symbol
                                                           : SW'(pmc_pkg::AlphabetSize - 1);
    assign mcl = (plen_reg == '0) ? LW'(1)
               : (plen_reg > LW'(pmc_pkg::PatternMax)) ? LW'(pmc_pkg::PatternMax) : plen_reg;
    assign jm1 = j_reg - LW'(1);
    assign dsym = (sym_rd < SW'(pmc_pkg::AlphabetSize)) ? sym_rd
                                                         : SW'(pmc_pkg::AlphabetSize - 1);
    assign dsa = dsym[AW-1:0];

    // Symbol store.
    assign sym_ra = i_reg[IW-1:0];
    pmc_ram #(.Width(SW), .Depth(pmc_pkg::PatternMax)) u_sym (
        .aclk(aclk), .we(cmd.load_wr && (mode_reg == pmc_pkg::MODE_LOAD)),
        .waddr(idx_reg), .wdata(sym_reg), .raddr(sym_ra), .rdata(sym_rd));

    // Previous-distance table: read at j for a compare, otherwise at i so that
    // dist[i] is ready when the pair compare starts.
    assign dist_ra = (cmd.rd_pair || cmd.text_cmp_rd) ? j_reg[IW-1:0] : i_reg[IW-1:0];
    assign dist_we = cmd.dist_wb;
    assign dist_wa = i_reg[IW-1:0];
    assign dist_wd = seen_reg[dsa] ? (i_reg - plast_reg[dsa]) : '0;
    pmc_ram #(.Width(LW), .Depth(pmc_pkg::PatternMax)) u_dist (
        .aclk(aclk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
        .raddr(dist_ra), .rdata(dist_rd_a));

    // Failure links: read at j-1 when following a link, otherwise at j.
    assign fail_ra = cmd.fol_rd ? jm1[IW-1:0] : j_reg[IW-1:0];
    assign fail_we = cmd.fail_init || cmd.fail_wr;
    assign fail_wa = cmd.fail_init ? '0 : i_reg[IW-1:0];
    assign fail_wd = cmd.fail_init ? '0 : j_reg + LW'(1);
    pmc_ram #(.Width(LW), .Depth(pmc_pkg::PatternMax)) u_fail (
        .aclk(aclk), .we(fail_we), .waddr(fail_wa), .wdata(fail_wd),
        .raddr(fail_ra), .rdata(fail_rd));

    assign lhs = pmc_pkg::windowed(mode_reg == pmc_pkg::MODE_TEXT ? rawd_reg
                                   : PW'(dist_q_reg), j_reg);
    assign nx = (fail_rd < j_reg) ? fail_rd : '0;
    assign link_len = (fail_rd >= mlen_reg) ? '0 : fail_rd;

    always_comb begin
        stat.clr_done  = (clr_reg == '0);
        stat.dist_last = (i_reg == mlen_reg - LW'(1));
        stat.fail_last = (i_reg >= mlen_reg);
        stat.j_zero    = (j_reg == '0);
        stat.eq        = (lhs == dist_rd_a);
        stat.j_is_end  = (j_reg == mlen_reg - LW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= LW'(1);
            mlen_reg <= LW'(1);
            pos_reg <= '0;
            cnt_reg <= '0;
            j_reg <= '0;
            seen_reg <= '0;
            clr_reg <= '0;
        end else begin
            if (cfg_we) plen_reg <= cfg_wdata;
            if (in_fire) begin
                mode_reg <= in_mode;
                sym_reg <= csym;
                idx_reg <= in_index;
                if (in_mode == pmc_pkg::MODE_PREP) begin
                    mlen_reg <= mcl;
                    i_reg <= '0;
                    clr_reg <= LW'(pmc_pkg::AlphabetSize);
                    seen_reg <= '0;
                end
                if (in_mode == pmc_pkg::MODE_TEXT) begin
                    rawd_reg <= seen_reg[csym[AW-1:0]] ? (pos_reg - last_reg[csym[AW-1:0]])
                                                        : '0;
                    if (j_reg >= mlen_reg) j_reg <= '0;
                    seen_reg[csym[AW-1:0]] <= 1'b1;
                    last_reg[csym[AW-1:0]] <= pos_reg;
                    pos_reg <= pos_reg + PW'(1);
                end
            end
            if (cmd.clr_step) clr_reg <= clr_reg - LW'(1);
            if (cmd.dist_wb) begin
                seen_reg[dsa] <= 1'b1;
                plast_reg[dsa] <= i_reg;
                i_reg <= stat.dist_last ? LW'(1) : i_reg + LW'(1);
            end
            if (cmd.fail_init) begin
                j_reg <= '0;
                seen_reg <= '0;
                pos_reg <= '0;
                cnt_reg <= '0;
            end
            // The prefix length starts from zero once the tables are built.
            if (cmd.fail_wr) begin
                j_reg <= stat.dist_last ? '0 : fail_wd;
                i_reg <= i_reg + LW'(1);
            end
            if (cmd.fol_take) j_reg <= nx;
            if (cmd.miss_step) j_reg <= j_reg + LW'(1);
            if (cmd.hit_step && cnt_reg != '1) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.link_take) j_reg <= link_len;
            if (cmd.out_load) begin
                out_found_reg <= cmd.link_take;
                out_count_reg <= (cmd.fail_init || cmd.fail_wr) ? '0 : cnt_reg;
                out_len_reg <= cmd.miss_step ? j_reg + LW'(1)
                             : cmd.link_take ? link_len
                             : (cmd.fail_init || cmd.fail_wr) ? '0 : j_reg;
            end
        end
    end

    // Capture dist[i], read in the cycle before the pair compare starts.
    always_ff @(posedge aclk) begin
        if (cmd.rd_pair) dist_q_reg <= dist_rd_a;
    end

    assign out_found = out_found_reg;
    assign out_count = out_count_reg;
    assign out_len = out_len_reg;
endmodule
`default_nettype wire

// File: design/parameterized_match_counter.sv
// Top level of the parameterized match counter.
// Takes one request at a time and returns one result request for each; the input
// is ready again in the cycle after the result is taken. A text symbol is compared
// and then follows failure links until it matches or the prefix is empty; a
// prepare builds the distance and failure tables after the letter history sweep.
// The table RAMs have a single read port.
`default_nettype none
module parameterized_match_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,     // pattern_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // mode[1:0], symbol[6:2], pattern_index[16:7]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata        // match_found[0], match_count[32:1],
                                            // matched_length[43:33]
);
    pmc_pkg::cmd_t  cmd;
    pmc_pkg::stat_t stat;
    logic in_fire, out_fire, found;
    logic [31:0] count;
    logic [10:0] mlen;

    // A request is taken when both valid and ready are high.
    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    pmc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_mode(s_tdata[1:0]),
        .out_fire(out_fire), .stat(stat), .cmd(cmd), .in_ready(s_tready),
        .out_valid(m_tvalid));

    pmc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_fire(in_fire), .in_mode(s_tdata[1:0]), .in_symbol(s_tdata[6:2]),
        .in_index(s_tdata[16:7]), .cmd(cmd), .stat(stat), .out_found(found),
        .out_count(count), .out_len(mlen));

    assign m_tdata = {4'd0, mlen, count, found};
endmodule
`default_nettype wire
